// File: hdl/gtr_pkg.sv
// Package: payload, command and class-state types plus the expansion tables of the translator.
package gtr_pkg;

    localparam int CharWidth  = 16;
    localparam int FifoDepth  = 4;
    localparam int FifoPtrW   = $clog2(FifoDepth);
    localparam int FifoCntW   = $clog2(FifoDepth + 1);
    localparam int StepWidth  = 3;

    // ASCII code units used by the translation
    localparam logic [CharWidth-1:0] CH_BANG   = 16'h0021;
    localparam logic [CharWidth-1:0] CH_DOLLAR = 16'h0024;
    localparam logic [CharWidth-1:0] CH_LPAREN = 16'h0028;
    localparam logic [CharWidth-1:0] CH_RPAREN = 16'h0029;
    localparam logic [CharWidth-1:0] CH_STAR   = 16'h002A;
    localparam logic [CharWidth-1:0] CH_PLUS   = 16'h002B;
    localparam logic [CharWidth-1:0] CH_DOT    = 16'h002E;
    localparam logic [CharWidth-1:0] CH_SLASH  = 16'h002F;
    localparam logic [CharWidth-1:0] CH_QMARK  = 16'h003F;
    localparam logic [CharWidth-1:0] CH_LBRACK = 16'h005B;
    localparam logic [CharWidth-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CharWidth-1:0] CH_RBRACK = 16'h005D;
    localparam logic [CharWidth-1:0] CH_CARET  = 16'h005E;
    localparam logic [CharWidth-1:0] CH_LBRACE = 16'h007B;
    localparam logic [CharWidth-1:0] CH_PIPE   = 16'h007C;
    localparam logic [CharWidth-1:0] CH_RBRACE = 16'h007D;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [CharWidth-1:0] pattern_char;
    } in_t;

    typedef struct packed {
        logic [CharWidth-1:0] out_char;
        logic                 char_valid;
        logic                 run_last;
        logic                 pattern_done;
        logic                 aborted;
    } out_t;

    typedef enum logic [1:0] {
        CLS_OUT,
        CLS_OPEN,
        CLS_NEGATED,
        CLS_BODY
    } class_state_t;

    typedef enum logic [2:0] {
        CMD_LITERAL,
        CMD_ESCAPE,
        CMD_STAR,
        CMD_QMARK,
        CMD_STATUS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [CharWidth-1:0] ch;
        logic                 aborted;
    } cmd_t;

    // Index of the last result a command produces
    function automatic logic [StepWidth-1:0] cmd_last(input cmd_kind_t kind);
        logic [StepWidth-1:0] last;
        unique case (kind)
            CMD_ESCAPE: last = StepWidth'(1);
            CMD_STAR:   last = StepWidth'(4);
            CMD_QMARK:  last = StepWidth'(3);
            default:    last = StepWidth'(0);
        endcase
        return last;
    endfunction

    // Code unit of result number step for a character command
    function automatic logic [CharWidth-1:0] cmd_char(input cmd_t cmd,
                                                      input logic [StepWidth-1:0] step);
        logic [CharWidth-1:0] ch;
        ch = cmd.ch;
        unique case (cmd.kind)
            CMD_ESCAPE: ch = (step == StepWidth'(0)) ? CH_BSLASH : cmd.ch;
            CMD_STAR, CMD_QMARK: begin
                unique case (step)
                    StepWidth'(0): ch = CH_LBRACK;
                    StepWidth'(1): ch = CH_CARET;
                    StepWidth'(2): ch = CH_SLASH;
                    StepWidth'(3): ch = CH_RBRACK;
                    default:       ch = CH_STAR;
                endcase
            end
            CMD_STATUS: ch = '0;
            default:    ch = cmd.ch;
        endcase
        return ch;
    endfunction

    // Metacharacters escaped outside a class
    function automatic logic is_meta(input logic [CharWidth-1:0] c);
        return (c == CH_BSLASH) || (c == CH_DOLLAR) || (c == CH_LPAREN) ||
               (c == CH_RPAREN) || (c == CH_PLUS) || (c == CH_DOT) ||
               (c == CH_CARET) || (c == CH_LBRACE) || (c == CH_PIPE) ||
               (c == CH_RBRACE);
    endfunction

endpackage

// File: hdl/glob_to_regex_translator_unit.sv
// Top level of the wildcard-to-regular-expression translator.
// Each pattern transaction yields zero to five result transactions: a plain
// character gives one, an escaped one two, '?' four and '*' five; a slash inside
// a class and anything after it give none, and an end transaction gives one
// status result. Input is taken every cycle while the four-entry command queue
// has room; the output register delivers one result per cycle while m_ready is
// high and a command is queued, so the sustained rate is limited by that single
// output port, and a transaction that yields nothing is still accepted at the
// input like any other.
module glob_to_regex_translator_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gtr_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output gtr_pkg::out_t m_payload
);

    logic          q_push, q_full, q_pop, q_empty;
    gtr_pkg::cmd_t push_cmd, head_cmd;

    gtr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    gtr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    gtr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: hdl/gtr_front.sv
// Front end: accepts pattern transactions, tracks class state and emits expansion commands.
module gtr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gtr_pkg::in_t      s_payload,
    input  logic              q_full,
    output logic              q_push,
    output gtr_pkg::cmd_t     q_cmd
);

    gtr_pkg::class_state_t mode_reg, mode_next;
    logic                  abort_reg, abort_next;
    logic                  accept;
    logic                  emit;
    logic [gtr_pkg::CharWidth-1:0] c;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign c       = s_payload.pattern_char;
    assign q_push  = accept && emit;

    // Next class state and abort flag
    always_comb begin
        mode_next  = mode_reg;
        abort_next = abort_reg;
        if (s_payload.action == gtr_pkg::ACT_END) begin
            mode_next  = gtr_pkg::CLS_OUT;
            abort_next = 1'b0;
        end else if (!abort_reg) begin
            unique case (mode_reg)
                gtr_pkg::CLS_OUT: begin
                    if (c == gtr_pkg::CH_LBRACK) mode_next = gtr_pkg::CLS_OPEN;
                end
                gtr_pkg::CLS_OPEN: begin
                    if (c == gtr_pkg::CH_BANG) begin
                        mode_next = gtr_pkg::CLS_NEGATED;
                    end else if (c == gtr_pkg::CH_SLASH) begin
                        mode_next  = gtr_pkg::CLS_BODY;
                        abort_next = 1'b1;
                    end else begin
                        mode_next = gtr_pkg::CLS_BODY;
                    end
                end
                gtr_pkg::CLS_NEGATED: begin
                    mode_next = gtr_pkg::CLS_BODY;
                    if (c == gtr_pkg::CH_SLASH) abort_next = 1'b1;
                end
                gtr_pkg::CLS_BODY: begin
                    if (c == gtr_pkg::CH_RBRACK) mode_next = gtr_pkg::CLS_OUT;
                    else if (c == gtr_pkg::CH_SLASH) abort_next = 1'b1;
                end
                default: mode_next = gtr_pkg::CLS_OUT;
            endcase
        end
    end

    // Classify the item into a command
    always_comb begin
        q_cmd.kind    = gtr_pkg::CMD_LITERAL;
        q_cmd.ch      = c;
        q_cmd.aborted = 1'b0;
        emit          = 1'b1;
        if (s_payload.action == gtr_pkg::ACT_END) begin
            q_cmd.kind    = gtr_pkg::CMD_STATUS;
            q_cmd.aborted = abort_reg;
        end else if (abort_reg) begin
            emit = 1'b0;
        end else begin
            unique case (mode_reg)
                gtr_pkg::CLS_OUT: begin
                    if (c == gtr_pkg::CH_STAR)       q_cmd.kind = gtr_pkg::CMD_STAR;
                    else if (c == gtr_pkg::CH_QMARK) q_cmd.kind = gtr_pkg::CMD_QMARK;
                    else if (gtr_pkg::is_meta(c))    q_cmd.kind = gtr_pkg::CMD_ESCAPE;
                end
                gtr_pkg::CLS_OPEN: begin
                    if (c == gtr_pkg::CH_BANG)        q_cmd.ch   = gtr_pkg::CH_CARET;
                    else if (c == gtr_pkg::CH_SLASH)  emit       = 1'b0;
                    else if (c == gtr_pkg::CH_BSLASH) q_cmd.kind = gtr_pkg::CMD_ESCAPE;
                end
                gtr_pkg::CLS_NEGATED: begin
                    if (c == gtr_pkg::CH_SLASH)       emit       = 1'b0;
                    else if (c == gtr_pkg::CH_BSLASH) q_cmd.kind = gtr_pkg::CMD_ESCAPE;
                end
                gtr_pkg::CLS_BODY: begin
                    if (c == gtr_pkg::CH_SLASH)       emit       = 1'b0;
                    else if (c == gtr_pkg::CH_BSLASH) q_cmd.kind = gtr_pkg::CMD_ESCAPE;
                end
                default: emit = 1'b0;
            endcase
        end
    end

    // Advance state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= gtr_pkg::CLS_OUT;
            abort_reg <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            abort_reg <= abort_next;
        end
    end

endmodule

// File: hdl/gtr_fifo.sv
// Command queue: short register FIFO between the front and back ends.
module gtr_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gtr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output gtr_pkg::cmd_t head_cmd
);

    gtr_pkg::cmd_t                 mem_reg [gtr_pkg::FifoDepth];
    logic [gtr_pkg::FifoPtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [gtr_pkg::FifoCntW-1:0]  count_reg, count_next;
    logic                          do_push, do_pop;

    assign full     = (count_reg == gtr_pkg::FifoCntW'(gtr_pkg::FifoDepth));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    // Store incoming command
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/gtr_back.sv
// Back end: expands queued commands into result transactions through an output register.
module gtr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  gtr_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output gtr_pkg::out_t m_payload
);

    logic [gtr_pkg::StepWidth-1:0] step_reg, step_next;
    logic                          m_valid_reg, m_valid_next;
    gtr_pkg::out_t                 out_reg, out_next;
    logic                          emit, last;

    assign last      = (step_reg == gtr_pkg::cmd_last(q_cmd.kind));
    assign emit      = !q_empty && (!m_valid_reg || m_ready);
    assign q_pop     = emit && last;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // Build the next result and step
    always_comb begin
        out_next.out_char     = gtr_pkg::cmd_char(q_cmd, step_reg);
        out_next.char_valid   = (q_cmd.kind != gtr_pkg::CMD_STATUS);
        out_next.run_last     = last;
        out_next.pattern_done = (q_cmd.kind == gtr_pkg::CMD_STATUS);
        out_next.aborted      = (q_cmd.kind == gtr_pkg::CMD_STATUS) && q_cmd.aborted;
        step_next             = last ? '0 : step_reg + 1'b1;
        m_valid_next          = emit || (m_valid_reg && !m_ready);
    end

    // Hold payload until taken
    always_ff @(posedge aclk) begin
        if (emit) out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (emit) step_reg <= step_next;
        end
    end

endmodule
